// ----- hdl/pgat_pkg.sv -----
package pgat_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned OUT_CNT_W   = 6;

  localparam logic OPC_ADVERTISE = 1'b0;
  localparam logic OPC_SWEEP     = 1'b1;

  localparam logic [1:0] REG_HOLD_TIME = 2'd0;

  typedef enum logic [1:0] {
    TOK_ADV,
    TOK_SWEEP,
    TOK_INS
  } tok_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] net_addr;
    logic [5:0]  prefix_len;
    logic [31:0] gw_addr;
    logic [15:0] seq;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic                 inserted;
    logic                 full_res;
    logic                 changed;
    logic [OUT_CNT_W-1:0] removed_count;
    logic [OUT_CNT_W-1:0] entry_count;
  } out_t;

  // query beat passed from cell to cell
  typedef struct packed {
    logic             valid;
    tok_op_e          op;
    logic [31:0]      net;
    logic [5:0]       pfx;
    logic [31:0]      gw;
    logic [15:0]      seq;
    logic [31:0]      expiry;
    logic [31:0]      now;
    logic             found;
    logic             placed;
    logic [CNT_W-1:0] removed;
    logic [CNT_W-1:0] cnt;
  } tok_t;

endpackage

// ----- hdl/pgat_cell.sv -----
module pgat_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pgat_pkg::tok_t tok_i,
  output pgat_pkg::tok_t tok_o
);

  logic        valid_q, valid_d;
  logic [31:0] net_q;
  logic [5:0]  pfx_q;
  logic [31:0] gw_q;
  logic [15:0] seq_q;
  logic [31:0] expiry_q;

  pgat_pkg::tok_t tok_q, tok_d;
  logic match, refresh, fill, kill;

  assign match = valid_q && (net_q == tok_i.net) && (gw_q == tok_i.gw) && (pfx_q == tok_i.pfx);

  always_comb begin
    tok_d   = tok_i;
    refresh = 1'b0;
    fill    = 1'b0;
    kill    = 1'b0;
    if (tok_i.valid) begin
      case (tok_i.op)
        pgat_pkg::TOK_ADV: begin
          if (match && !tok_i.found) begin
            refresh     = 1'b1;
            tok_d.found = 1'b1;
          end
        end
        pgat_pkg::TOK_INS: begin
          if (!valid_q && !tok_i.placed) begin
            fill         = 1'b1;
            tok_d.placed = 1'b1;
          end
        end
        pgat_pkg::TOK_SWEEP: begin
          if (valid_q && (expiry_q < tok_i.now)) begin
            kill          = 1'b1;
            tok_d.removed = tok_i.removed + pgat_pkg::CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
    valid_d   = (valid_q && !kill) || fill;
    tok_d.cnt = tok_i.cnt + pgat_pkg::CNT_W'(valid_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill) begin
      net_q <= tok_i.net;
      pfx_q <= tok_i.pfx;
      gw_q  <= tok_i.gw;
    end
    if (fill || refresh) begin
      seq_q    <= tok_i.seq;
      expiry_q <= tok_i.expiry;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- hdl/prefix_gateway_aging_table.sv -----
// Channel | Direction | Handshake              | Beat
// in      | input     | in_valid_i/in_ready_o  | pgat_pkg::in_t
// out     | output    | out_valid_o/out_ready_i| pgat_pkg::out_t
// cfg     | input     | APB, pready always 1   | hold_time at 0
// A beat walks one entry cell per cycle. Sweep, refresh or full: the beat is registered
// in launch_q, passes every cell, lands in res_q, then out_q; the next beat is taken in ST_IDLE.
// An insert walks the chain twice, first as an advert and then as an insert token.
// One item at a time; a new beat is taken while a result waits.
// Reset clears the valid bits at once, no clearing pass.
// A stalled result holds the finished item; the next one waits for it before leaving.
module prefix_gateway_aging_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pgat_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pgat_pkg::out_t out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  pgat_pkg::state_e state_q, state_d;
  logic [31:0]      hold_q;
  logic             changed_q;
  pgat_pkg::tok_t   tok [pgat_pkg::TABLE_DEPTH+1];
  pgat_pkg::tok_t   launch_q;
  pgat_pkg::tok_t   tail;
  pgat_pkg::out_t   res_q, res_d, out_q;
  logic             out_valid_q;
  logic             acc, launch_ins, res_load, out_load, need_ins;

  assign pready = 1'b1;
  assign prdata = hold_q;

  assign tok[0] = launch_q;
  assign tail   = tok[pgat_pkg::TABLE_DEPTH];

  for (genvar i = 0; i < pgat_pkg::TABLE_DEPTH; i++) begin : g_cell
    pgat_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
  end

  assign need_ins = (tail.op == pgat_pkg::TOK_ADV) && !tail.found &&
                    (tail.cnt != pgat_pkg::CNT_W'(pgat_pkg::TABLE_DEPTH));

  always_comb begin
    state_d = state_q;
    case (state_q)
      pgat_pkg::ST_IDLE: if (in_valid_i) state_d = pgat_pkg::ST_SCAN;
      pgat_pkg::ST_SCAN: begin
        if (tail.valid) state_d = need_ins ? pgat_pkg::ST_INS : pgat_pkg::ST_DONE;
      end
      pgat_pkg::ST_INS:  if (tail.valid) state_d = pgat_pkg::ST_DONE;
      pgat_pkg::ST_DONE: if (!out_valid_q || out_ready_i) state_d = pgat_pkg::ST_IDLE;
      default:           state_d = pgat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == pgat_pkg::ST_IDLE);
    acc        = in_ready_o && in_valid_i;
    launch_ins = (state_q == pgat_pkg::ST_SCAN) && tail.valid && need_ins;
    res_load   = tail.valid && (state_q == pgat_pkg::ST_INS ||
                 (state_q == pgat_pkg::ST_SCAN && !need_ins));
    out_load   = (state_q == pgat_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    res_d               = '0;
    res_d.entry_count   = pgat_pkg::OUT_CNT_W'(tail.cnt);
    res_d.changed       = changed_q;
    case (tail.op)
      pgat_pkg::TOK_ADV: begin
        res_d.hit      = tail.found;
        res_d.full_res = !tail.found;
      end
      pgat_pkg::TOK_INS: begin
        res_d.inserted = 1'b1;
        res_d.changed  = 1'b1;
      end
      pgat_pkg::TOK_SWEEP: begin
        res_d.removed_count = pgat_pkg::OUT_CNT_W'(tail.removed);
        res_d.changed       = (tail.removed != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pgat_pkg::ST_IDLE;
      hold_q      <= '0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
      launch_q    <= '0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && (paddr == pgat_pkg::REG_HOLD_TIME)) hold_q <= pwdata;
      if (res_load) changed_q <= res_d.changed;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      launch_q.valid <= acc || launch_ins;
      if (acc) begin
        launch_q.op      <= (in_data_i.opcode == pgat_pkg::OPC_SWEEP) ?
                            pgat_pkg::TOK_SWEEP : pgat_pkg::TOK_ADV;
        launch_q.net     <= in_data_i.net_addr;
        launch_q.pfx     <= in_data_i.prefix_len;
        launch_q.gw      <= in_data_i.gw_addr;
        launch_q.seq     <= in_data_i.seq;
        launch_q.now     <= in_data_i.now;
        launch_q.expiry  <= in_data_i.now + hold_q;
        launch_q.found   <= 1'b0;
        launch_q.placed  <= 1'b0;
        launch_q.removed <= '0;
        launch_q.cnt     <= '0;
      end else if (launch_ins) begin
        launch_q.op      <= pgat_pkg::TOK_INS;
        launch_q.net     <= tail.net;
        launch_q.pfx     <= tail.pfx;
        launch_q.gw      <= tail.gw;
        launch_q.seq     <= tail.seq;
        launch_q.now     <= tail.now;
        launch_q.expiry  <= tail.expiry;
        launch_q.found   <= 1'b0;
        launch_q.placed  <= 1'b0;
        launch_q.removed <= '0;
        launch_q.cnt     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res_d;
    if (out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- dv/tb_prefix_gateway_aging_table.sv -----
module tb_prefix_gateway_aging_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         KEY_POOL       = 40;
  localparam int         PHASES         = 6;
  localparam int         PHASE_ITEMS    = 200;
  localparam int         SLOW_LATENCY   = 2 * pgat_pkg::TABLE_DEPTH + 4;

  logic           clk_i;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  pgat_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  pgat_pkg::out_t out_data_o;
  logic           psel        = 1'b0;
  logic           penable     = 1'b0;
  logic           pwrite      = 1'b0;
  logic [1:0]     paddr       = '0;
  logic [31:0]    pwdata      = '0;
  logic [31:0]    prdata;
  logic           pready;

  prefix_gateway_aging_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // predictor state
  logic [31:0] hold_time_m = '0;
  logic        changed_m   = 1'b0;
  logic        tab_valid  [pgat_pkg::TABLE_DEPTH];
  logic [31:0] tab_net    [pgat_pkg::TABLE_DEPTH];
  logic [5:0]  tab_pfx    [pgat_pkg::TABLE_DEPTH];
  logic [31:0] tab_gw     [pgat_pkg::TABLE_DEPTH];
  logic [31:0] tab_expiry [pgat_pkg::TABLE_DEPTH];

  pgat_pkg::in_t  adverts_to_send [$];
  pgat_pkg::out_t awaited_results [$];
  int   n_accepted   = 0;
  int   n_checked    = 0;
  int   fail_cnt     = 0;
  logic in_took      = 1'b0;
  logic calm         = 1'b0;
  int   stall_left   = 0;
  logic stalled_once = 1'b0;

  logic [31:0] key_net [KEY_POOL];
  logic [5:0]  key_pfx [KEY_POOL];
  logic [31:0] key_gw  [KEY_POOL];
  logic [31:0] tick = '0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_prefix_gateway_aging_table failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", n_checked, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic pgat_pkg::out_t aging_table_step(input pgat_pkg::in_t it);
    pgat_pkg::out_t r;
    logic [31:0]    expiry;
    int             slot;
    int             removed;
    int             live;
    r       = '0;
    slot    = -1;
    removed = 0;
    live    = 0;
    if (it.opcode == pgat_pkg::OPC_ADVERTISE) begin
      expiry = it.now + hold_time_m;
      for (int i = 0; i < pgat_pkg::TABLE_DEPTH; i++)
        if (slot < 0 && tab_valid[i] && tab_net[i] == it.net_addr &&
            tab_gw[i] == it.gw_addr && tab_pfx[i] == it.prefix_len)
          slot = i;
      if (slot >= 0) begin
        r.hit = 1'b1;
        tab_expiry[slot] = expiry;
      end else begin
        for (int i = 0; i < pgat_pkg::TABLE_DEPTH; i++)
          if (slot < 0 && !tab_valid[i])
            slot = i;
        if (slot >= 0) begin
          tab_valid[slot]  = 1'b1;
          tab_net[slot]    = it.net_addr;
          tab_pfx[slot]    = it.prefix_len;
          tab_gw[slot]     = it.gw_addr;
          tab_expiry[slot] = expiry;
          r.inserted = 1'b1;
          changed_m  = 1'b1;
        end else begin
          r.full_res = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < pgat_pkg::TABLE_DEPTH; i++)
        if (tab_valid[i] && tab_expiry[i] < it.now) begin
          tab_valid[i] = 1'b0;
          removed++;
        end
      changed_m = (removed != 0);
    end
    for (int i = 0; i < pgat_pkg::TABLE_DEPTH; i++)
      if (tab_valid[i])
        live++;
    r.changed       = changed_m;
    r.removed_count = pgat_pkg::OUT_CNT_W'(removed);
    r.entry_count   = pgat_pkg::OUT_CNT_W'(live);
    return r;
  endfunction

  function automatic pgat_pkg::in_t advert(input logic [31:0] net, input logic [5:0] pfx,
                                           input logic [31:0] gw, input logic [15:0] seq,
                                           input logic [31:0] now);
    pgat_pkg::in_t it;
    it.opcode     = pgat_pkg::OPC_ADVERTISE;
    it.net_addr   = net;
    it.prefix_len = pfx;
    it.gw_addr    = gw;
    it.seq        = seq;
    it.now        = now;
    return it;
  endfunction

  function automatic pgat_pkg::in_t sweep_at(input logic [31:0] now);
    pgat_pkg::in_t it;
    it = advert($urandom, 6'($urandom_range(0, 32)), $urandom, 16'($urandom), now);
    it.opcode = pgat_pkg::OPC_SWEEP;
    return it;
  endfunction

  function automatic pgat_pkg::in_t random_item(input int sweep_pct, input logic [31:0] step);
    pgat_pkg::in_t it;
    int            k;
    tick = tick + $urandom_range(0, step);
    if ($urandom_range(0, 99) < sweep_pct) begin
      it = sweep_at(tick);
    end else if ($urandom_range(0, 99) < 80) begin
      k  = $urandom_range(0, KEY_POOL - 1);
      it = advert(key_net[k], key_pfx[k], key_gw[k], 16'($urandom), tick);
    end else begin
      it = advert($urandom, 6'($urandom_range(0, 32)), $urandom, 16'($urandom), tick);
    end
    if ($urandom_range(0, 99) < 5)
      it.now = $urandom;
    return it;
  endfunction

  // waits at rising edges so the counters are read before this edge updates them
  task automatic wait_idle();
    do @(posedge clk_i);
    while (adverts_to_send.size() != 0 || in_valid_i || n_accepted != n_checked);
  endtask

  task automatic write_hold_time(input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pgat_pkg::REG_HOLD_TIME;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    paddr   <= 2'($urandom_range(1, 3));
    pwdata  <= ~val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= pgat_pkg::REG_HOLD_TIME;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== val)
      report_mismatch($sformatf("hold_time read %0h expected %0h", prdata, val));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    hold_time_m = val;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (adverts_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
        in_data_i  <= adverts_to_send.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (n_checked == 150 && !stalled_once) begin
      stalled_once <= 1'b1;
      stall_left   <= 400;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= calm || $urandom_range(0, 99) >= 8;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pgat_pkg::out_t want;
    in_took <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        awaited_results.push_back(aging_table_step(in_data_i));
        n_accepted <= n_accepted + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = awaited_results.pop_front();
          check_field("hit", 32'(out_data_o.hit), 32'(want.hit));
          check_field("inserted", 32'(out_data_o.inserted), 32'(want.inserted));
          check_field("full_res", 32'(out_data_o.full_res), 32'(want.full_res));
          check_field("changed", 32'(out_data_o.changed), 32'(want.changed));
          check_field("removed_count", 32'(out_data_o.removed_count),
                      32'(want.removed_count));
          check_field("entry_count", 32'(out_data_o.entry_count), 32'(want.entry_count));
          n_checked <= n_checked + 1;
        end
      end
    end
  end

  initial begin
    logic [31:0] phase_hold  [PHASES];
    int          phase_sweep [PHASES];
    logic [31:0] phase_step  [PHASES];
    int          k;
    for (int i = 0; i < pgat_pkg::TABLE_DEPTH; i++)
      tab_valid[i] = 1'b0;
    for (int i = 0; i < KEY_POOL; i++) begin
      key_net[i] = $urandom;
      key_pfx[i] = 6'($urandom_range(0, 32));
      key_gw[i]  = $urandom;
      // near misses: copy the previous key and change one part
      if (i > 0 && $urandom_range(0, 99) < 30) begin
        k = $urandom_range(0, 2);
        key_net[i] = (k == 0) ? key_net[i] : key_net[i-1];
        key_pfx[i] = (k == 1) ? key_pfx[i] : key_pfx[i-1];
        key_gw[i]  = (k == 2) ? key_gw[i]  : key_gw[i-1];
      end
    end
    phase_hold  = '{32'd0, 32'd1000, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1, $urandom};
    phase_sweep = '{25, 20, 30, 3, 25, 15};
    phase_step  = '{32'd3, 32'd200, 32'd3, 32'd16, 32'd2, (phase_hold[5] >> 5) + 32'd1};

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_hold_time(32'd0);
    adverts_to_send.push_back(sweep_at(32'd0));
    adverts_to_send.push_back(advert(32'd0, 6'd0, 32'd0, 16'd0, 32'd0));
    adverts_to_send.push_back(advert(32'd0, 6'd0, 32'd0, 16'hFFFF, 32'd5));
    adverts_to_send.push_back(advert(32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 16'hFFFF,
                                     32'hFFFF_FFFF));
    adverts_to_send.push_back(advert(32'd0, 6'd1, 32'd0, 16'd1, 32'd3));
    adverts_to_send.push_back(advert(32'd0, 6'd0, 32'd1, 16'd2, 32'd3));
    adverts_to_send.push_back(advert(32'd1, 6'd0, 32'd0, 16'd3, 32'd3));
    adverts_to_send.push_back(sweep_at(32'd5));
    adverts_to_send.push_back(advert(32'd0, 6'd0, 32'd0, 16'd4, 32'd6));
    adverts_to_send.push_back(sweep_at(32'd6));
    adverts_to_send.push_back(advert(32'd0, 6'd1, 32'd0, 16'd5, 32'd7));
    adverts_to_send.push_back(sweep_at(32'hFFFF_FFFF));
    wait_idle();

    // expiry wraps past zero
    write_hold_time(32'hFFFF_FFFF);
    adverts_to_send.push_back(advert(32'h0A00_0000, 6'd8, 32'h0A00_0001, 16'd7, 32'd1));
    adverts_to_send.push_back(advert(32'h0A00_0000, 6'd8, 32'h0A00_0001, 16'd8, 32'd0));
    adverts_to_send.push_back(advert(32'hC0A8_0000, 6'd16, 32'hC0A8_0001, 16'd9, 32'd2));
    adverts_to_send.push_back(sweep_at(32'd2));
    adverts_to_send.push_back(sweep_at(32'd0));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_hold_time(phase_hold[p]);
      calm = (p == 3);
      repeat (PHASE_ITEMS)
        adverts_to_send.push_back(random_item(phase_sweep[p], phase_step[p]));
    end

    wait_idle();
    repeat (SLOW_LATENCY + 8) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("tb_prefix_gateway_aging_table passed");
    else
      $display("tb_prefix_gateway_aging_table failed");
    $finish;
  end

endmodule
